### rtl/shxd_pkg.sv
// ----------------------------------------------------------------------------
// Sync-header deframer package
// Shared constants and types for the sync-header XOR-checksum packet deframer.
// ----------------------------------------------------------------------------
package shxd_pkg;

	localparam int BYTE_W           = 8;
	localparam int PACKET_BYTES_DEF = 23;
	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hB4;

	// Payload starts after the two sync bytes and spans at most 20 bytes.
	localparam int PAYLOAD_FIRST = 2;
	localparam int PAYLOAD_BYTES = 20;
	localparam int PAYLOAD_W     = PAYLOAD_BYTES * BYTE_W;
	localparam int LOW_W         = 64;
	localparam int MID_W         = 64;
	localparam int HIGH_W        = 32;

	// Outcome of one window check.
	typedef struct packed {
		logic hdr_hit;
		logic sum_ok;
	} shxd_chk_t;

endpackage

### rtl/shxd_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// One byte of the sliding window; takes its neighbor's byte on every shift.
// ----------------------------------------------------------------------------
module shxd_cell (
	input  logic                        clk,
	input  logic                        shift_en,
	input  logic [shxd_pkg::BYTE_W-1:0] byte_in,
	output logic [shxd_pkg::BYTE_W-1:0] byte_out
);
	import shxd_pkg::*;

	logic [BYTE_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;

endmodule

### rtl/shxd_check.sv
// ----------------------------------------------------------------------------
// Window check
// Compares the two sync bytes with the header and the XOR of the body with
// the trailing checksum byte.
// ----------------------------------------------------------------------------
module shxd_check #(
	parameter int PACKET_BYTES = shxd_pkg::PACKET_BYTES_DEF
) (
	input  logic [PACKET_BYTES-1:0][shxd_pkg::BYTE_W-1:0] win,
	input  logic [shxd_pkg::BYTE_W-1:0]                   header,
	output shxd_pkg::shxd_chk_t                           chk
);
	import shxd_pkg::*;

	localparam int BODY_BYTES = PACKET_BYTES - 3;

	logic [BYTE_W-1:0][BODY_BYTES-1:0] col;
	logic [BYTE_W-1:0]                 sum;

	// Each checksum bit is an independent XOR tree over one bit column.
	for (genvar b = 0; b < BYTE_W; b++) begin : g_bit
		for (genvar i = 0; i < BODY_BYTES; i++) begin : g_byte
			assign col[b][i] = win[i + PAYLOAD_FIRST][b];
		end
		assign sum[b] = ^col[b];
	end

	always_comb begin
		chk.hdr_hit = (win[0] == header) && (win[1] == header);
		chk.sum_ok  = (sum == win[PACKET_BYTES-1]);
	end

endmodule

### rtl/sync_header_xor_packet_deframer.sv
// ----------------------------------------------------------------------------
// Sync-header XOR-checksum packet deframer
// Slides a byte window over the received stream and reports framed packets.
// ----------------------------------------------------------------------------
// Path: the byte completing the packet window is taken into the window
//   cells and the check stage, and its result is then registered on out_valid.
// Throughput: one byte per cycle while in_stall is low; the window chain shifts on every accept.
// Reset: clears the fill count, the check stage and the output valid, and
//   loads the header register with 0xB4. Window cells are not reset.
// ----------------------------------------------------------------------------
module sync_header_xor_packet_deframer #(
	parameter int PACKET_BYTES = shxd_pkg::PACKET_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [shxd_pkg::BYTE_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [shxd_pkg::BYTE_W-1:0] rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        packet_ok,
	output logic [shxd_pkg::LOW_W-1:0]  payload_low,
	output logic [shxd_pkg::MID_W-1:0]  payload_mid,
	output logic [shxd_pkg::HIGH_W-1:0] payload_high
);
	import shxd_pkg::*;

	localparam int FILL_W = $clog2(PACKET_BYTES + 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(PACKET_BYTES);

	// The window is a chain of byte cells. Cell 0 holds the oldest byte and
	// the newest byte enters the last cell; every accept moves each byte one
	// cell toward cell 0.
	logic [PACKET_BYTES-1:0][BYTE_W-1:0] win;
	logic                                in_acc;

	for (genvar i = 0; i < PACKET_BYTES; i++) begin : g_cell
		logic [BYTE_W-1:0] cell_in;
		if (i == PACKET_BYTES - 1) begin : g_tail
			assign cell_in = rx_byte;
		end else begin : g_link
			assign cell_in = win[i + 1];
		end
		shxd_cell u_cell (
			.clk      (clk),
			.shift_en (in_acc),
			.byte_in  (cell_in),
			.byte_out (win[i])
		);
	end

	// Header register; the user must write it only while the block is idle (not enforced here).
	logic [BYTE_W-1:0] header_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (cfg_we) begin
			header_q <= cfg_wdata;
		end
	end

	// The check stage looks at the window in the cycle after each accepted
	// item. It can only retire when the output register can take a result;
	// while it waits, the input is stalled so the window stays put.
	logic        chk_s1;
	logic        out_valid_q;
	logic        out_load;
	logic        full_hit;
	logic        load_ok;
	shxd_chk_t   chk;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_eff;

	shxd_check #(
		.PACKET_BYTES (PACKET_BYTES)
	) u_check (
		.win    (win),
		.header (header_q),
		.chk    (chk)
	);

	assign out_load = !out_valid_q || !out_stall;
	assign in_stall = !out_load;
	assign in_acc   = in_valid && !in_stall;

	// A result appears only for a full window whose sync bytes match.
	assign full_hit = chk_s1 && (fill_q == FILL_FULL) && chk.hdr_hit;
	assign load_ok  = out_load && full_hit && chk.sum_ok;

	// A good packet empties the window, so the count restarts from zero
	// before the next byte (which may arrive in this same cycle) is counted.
	assign fill_eff = load_ok ? '0 : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			chk_s1 <= 1'b0;
		end else begin
			if (in_acc) begin
				fill_q <= (fill_eff == FILL_FULL) ? FILL_FULL : fill_eff + 1'b1;
				chk_s1 <= 1'b1;
			end else begin
				fill_q <= fill_eff;
				if (out_load) begin
					chk_s1 <= 1'b0;
				end
			end
		end
	end

	// Payload bytes at or beyond the checksum position read as zero.
	logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0] pay_c;
	logic [PAYLOAD_W-1:0]                 pay_q;
	logic                                 ok_q;

	for (genvar k = 0; k < PAYLOAD_BYTES; k++) begin : g_pay
		if (k + PAYLOAD_FIRST < PACKET_BYTES - 1) begin : g_live
			assign pay_c[k] = win[k + PAYLOAD_FIRST];
		end else begin : g_zero
			assign pay_c[k] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= full_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && full_hit) begin
			ok_q  <= chk.sum_ok;
			pay_q <= pay_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign packet_ok    = ok_q;
	assign payload_low  = pay_q[LOW_W-1:0];
	assign payload_mid  = pay_q[LOW_W+MID_W-1:LOW_W];
	assign payload_high = pay_q[PAYLOAD_W-1:LOW_W+MID_W];

	// A pending check that cannot retire must still be pending next cycle.
	a_chk_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chk_s1 && !out_load |=> chk_s1)
		else $error("pending window check was dropped");

	// After a good packet the window restarts: at most one new byte counted.
	a_fill_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load_ok |=> fill_q <= FILL_W'(1))
		else $error("fill count not restarted after good packet");

	// The fill count never passes the window length.
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_FULL)
		else $error("fill count exceeds window length");

	// A result is only loaded from a window that was actually checked.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && full_hit |=> out_valid_q && $past(chk_s1))
		else $error("result loaded without a window check");

endmodule

### sim/shxd_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer scoreboard
// Predicts the frames the deframer reports for each accepted byte and checks
// the frames it delivers, field by field, in order.
// ----------------------------------------------------------------------------
package shxd_tb_pkg;

	import shxd_pkg::*;

	localparam int FRAME_BYTES = PACKET_BYTES_DEF;

	typedef struct packed {
		logic              ok;
		logic [LOW_W-1:0]  low;
		logic [MID_W-1:0]  mid;
		logic [HIGH_W-1:0] high;
	} frame_t;

	class deframe_scoreboard;
		logic [BYTE_W-1:0] window [FRAME_BYTES];
		int unsigned       fill;
		logic [BYTE_W-1:0] header;
		frame_t            frames_q[$];
		int unsigned       mismatches;
		int unsigned       good_frames;
		int unsigned       bad_frames;
		int unsigned       bytes_in;

		function new();
			foreach (window[i]) window[i] = '0;
			fill        = 0;
			header      = HEADER_RESET;
			mismatches  = 0;
			good_frames = 0;
			bad_frames  = 0;
			bytes_in    = 0;
		endfunction

		function void set_header(logic [BYTE_W-1:0] value);
			header = value;
		endfunction

		function int unsigned pending();
			return frames_q.size();
		endfunction

		// Shift the byte in and, once the window is full and framed by two
		// header bytes, queue the frame the block has to report.
		function void note_byte(logic [BYTE_W-1:0] value);
			logic [BYTE_W-1:0]    sum;
			logic [PAYLOAD_W-1:0] body;
			frame_t               f;
			int                   pos;
			bytes_in++;
			for (int i = 0; i < FRAME_BYTES - 1; i++) window[i] = window[i + 1];
			window[FRAME_BYTES - 1] = value;
			if (fill < FRAME_BYTES) fill++;
			if (fill < FRAME_BYTES) return;
			if (window[0] != header || window[1] != header) return;
			sum = '0;
			for (int i = PAYLOAD_FIRST; i < FRAME_BYTES - 1; i++) sum ^= window[i];
			body = '0;
			for (int k = 0; k < PAYLOAD_BYTES; k++) begin
				pos = PAYLOAD_FIRST + k;
				if (pos < FRAME_BYTES - 1) body[BYTE_W*k +: BYTE_W] = window[pos];
			end
			f.ok   = (sum == window[FRAME_BYTES - 1]);
			f.low  = body[LOW_W-1:0];
			f.mid  = body[LOW_W +: MID_W];
			f.high = body[LOW_W + MID_W +: HIGH_W];
			if (f.ok) begin
				fill = 0;
				good_frames++;
			end else begin
				bad_frames++;
			end
			frames_q.push_back(f);
		endfunction

		// Every mismatch prints one line and is counted.
		task report(string what, logic [LOW_W-1:0] got, logic [LOW_W-1:0] want);
			mismatches++;
			$display("t=%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
		endtask

		task check_result(frame_t got);
			frame_t want;
			if (frames_q.size() == 0) begin
				report("frame with none pending", got.low, '0);
				return;
			end
			want = frames_q.pop_front();
			if (got.ok !== want.ok) report("packet_ok", got.ok, want.ok);
			if (got.low !== want.low) report("payload_low", got.low, want.low);
			if (got.mid !== want.mid) report("payload_mid", got.mid, want.mid);
			if (got.high !== want.high) report("payload_high", got.high, want.high);
		endtask
	endclass

endpackage

### sim/tb_sync_header_xor_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer testbench
// Streams framed and unframed bytes into the deframer under several header
// settings and flow-control patterns, and checks every reported frame.
// ----------------------------------------------------------------------------
module tb_sync_header_xor_packet_deframer;

	import shxd_pkg::*;
	import shxd_tb_pkg::*;

	// Cycles without any handshake before the run is declared hung. The
	// slowest correct stretch is a receiver stall run or a settle pause, both
	// far below this.
	localparam int WATCHDOG_LIMIT = 4000;
	// Six random segments, two per flow-control pattern, each under its own
	// header value.
	localparam int SEGMENTS      = 6;
	localparam int SEGMENT_BYTES = 150;
	// Pause before a header write, so that any check still in flight can retire.
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 8;
	localparam int BODY_BYTES    = FRAME_BYTES - 3;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [BYTE_W-1:0] cfg_wdata = '0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] rx_byte   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              packet_ok;
	logic [LOW_W-1:0]  payload_low;
	logic [MID_W-1:0]  payload_mid;
	logic [HIGH_W-1:0] payload_high;

	// Chance in a hundred that the sender holds back an item, and that the
	// receiver stalls in a given cycle.
	int                gap_pct   = 35;
	int                stall_pct = 82;
	int unsigned       headers_used = 0;
	logic [BYTE_W-1:0] stream_q[$];
	deframe_scoreboard sb;

	sync_header_xor_packet_deframer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.packet_ok    (packet_ok),
		.payload_low  (payload_low),
		.payload_mid  (payload_mid),
		.payload_high (payload_high)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Offers one byte, with random gaps ahead of it, and returns at the edge
	// that accepts it. Handshake signals are sampled at the edge, before the
	// block's own updates of that edge land.
	task automatic send_byte(input logic [BYTE_W-1:0] value);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_byte(value);
	endtask

	task automatic send_stream();
		foreach (stream_q[i]) send_byte(stream_q[i]);
		stream_q.delete();
	endtask

	// The header register is only written with the block idle: all frames
	// delivered and no check left in the pipeline.
	task automatic write_header(input logic [BYTE_W-1:0] value);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_header(value);
		headers_used++;
	endtask

	// A complete frame: two header bytes, the body, and the XOR of the body.
	// Body bytes sometimes copy the header so that false starts show up.
	// A corrupted frame gets a checksum that is off by a nonzero pattern.
	function automatic void add_frame(logic [BYTE_W-1:0] hdr, bit corrupt);
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] b;
		sum = '0;
		stream_q.push_back(hdr);
		stream_q.push_back(hdr);
		for (int k = 0; k < BODY_BYTES; k++) begin
			b = ($urandom_range(0, 9) == 0) ? hdr : BYTE_W'($urandom);
			sum ^= b;
			stream_q.push_back(b);
		end
		if (corrupt) sum ^= BYTE_W'($urandom_range(1, 255));
		stream_q.push_back(sum);
	endfunction

	// Right after reset, with the reset header: three header bytes and a body
	// of all-zero, all-one and alternating bytes. The first full window sees a
	// header pair and a wrong checksum, so it reports a failure and slides by
	// one byte; the byte after it closes a valid frame in the slid window.
	// No check happens while the window is still filling.
	task automatic build_directed();
		logic [BYTE_W-1:0] body_xor;
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] bad_sum;
		body_xor = '0;
		repeat (3) stream_q.push_back(HEADER_RESET);
		for (int i = 0; i < BODY_BYTES - 1; i++) begin
			b = {BYTE_W{i[0]}} ^ (i[1] ? 8'h55 : 8'h00);
			body_xor ^= b;
			stream_q.push_back(b);
		end
		bad_sum = ~(HEADER_RESET ^ body_xor);
		stream_q.push_back(bad_sum);
		stream_q.push_back(body_xor ^ bad_sum);
	endtask

	// Mostly well-formed frames with random content, mixed at random with
	// corrupted frames, truncated frames of one or two header bytes and up to
	// 12 random bytes, and loose noise that is rich in header bytes.
	task automatic build_segment(input logic [BYTE_W-1:0] hdr);
		int pick;
		while (stream_q.size() < SEGMENT_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				add_frame(hdr, 1'b0);
			end else if (pick < 70) begin
				add_frame(hdr, 1'b1);
			end else if (pick < 82) begin
				stream_q.push_back(hdr);
				if ($urandom_range(0, 1)) stream_q.push_back(hdr);
				repeat ($urandom_range(0, 12)) stream_q.push_back(BYTE_W'($urandom));
			end else begin
				repeat ($urandom_range(1, 6))
					stream_q.push_back(($urandom_range(0, 3) == 0) ? hdr : BYTE_W'($urandom));
			end
		end
	endtask

	// Receiver: takes a frame at every edge where one is offered and not
	// stalled, then draws the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(frame_t'{packet_ok, payload_low, payload_mid, payload_high});
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Watchdog: ends the run if no item moves on either side for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[sync_header_xor_packet_deframer] ERROR");
		$finish;
	end

	initial begin
		logic [BYTE_W-1:0] hdr;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		build_directed();
		send_stream();

		// Receiver-heavy stalls first, then sender-heavy gaps, then full
		// rate. The header goes through both extremes and random values.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 2)
				0: begin
					gap_pct   = 35;
					stall_pct = 82;
				end
				1: begin
					gap_pct   = 82;
					stall_pct = 35;
				end
				default: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
			endcase
			case (seg)
				0: hdr = 8'h00;
				1: hdr = 8'hFF;
				default: hdr = BYTE_W'($urandom);
			endcase
			write_header(hdr);
			build_segment(hdr);
			send_stream();
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes under %0d header settings and three flow-control patterns.",
			sb.bytes_in, headers_used + 1);
		$display("Frames checked: %0d valid, %0d with a bad checksum; %0d mismatches.",
			sb.good_frames, sb.bad_frames, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("[sync_header_xor_packet_deframer] OK");
		else
			$display("[sync_header_xor_packet_deframer] ERROR");
		$finish;
	end

endmodule

### sync_header_xor_packet_deframer.f
rtl/shxd_pkg.sv
rtl/shxd_cell.sv
rtl/shxd_check.sv
rtl/sync_header_xor_packet_deframer.sv
sim/shxd_tb_pkg.sv
sim/tb_sync_header_xor_packet_deframer.sv
